// File: hdl/block_work_from_compact_target_unit_defines.svh
`ifndef BLOCK_WORK_FROM_COMPACT_TARGET_UNIT_DEFINES_SVH
`define BLOCK_WORK_FROM_COMPACT_TARGET_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define BWCT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bwct: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted
`define BWCT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bwct: next-cycle check failed");

`endif

// File: hdl/bwct_pkg.sv
package bwct_pkg;

	localparam int WORK_W    = 256;
	localparam int WORD_W    = 64;
	localparam int NUM_WORDS = WORK_W / WORD_W;
	localparam int IDX_W     = $clog2(NUM_WORDS);
	localparam int STEP_W    = $clog2(WORK_W);
	localparam int CMP_W     = 32;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_DIV,
		ST_INC,
		ST_OUT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;  // latch compact word on input transfer
		logic load;     // decode target, set up numerator and divisor
		logic step;     // one restoring division step
		logic inc;      // quotient plus one
		logic shift;    // drop the word just transferred
	} ctrl_cmd_t;

endpackage

// File: hdl/bwct_dp.sv
module bwct_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bwct_pkg::ctrl_cmd_t               cmd,
	input  logic [bwct_pkg::CMP_W-1:0]        compact_bits,
	output logic [bwct_pkg::WORD_W-1:0]       work_word,
	output logic                              target_negative,
	output logic                              target_overflow
);
	import bwct_pkg::*;

	logic [CMP_W-1:0]  cmp_q;
	logic [WORK_W-1:0] rem_q;
	logic [WORK_W-1:0] quo_q;
	logic [WORK_W-1:0] den_q;
	logic              neg_q;
	logic              ovf_q;

	logic [7:0]        expo;
	logic [22:0]       mant;
	logic [22:0]       meff;
	logic [7:0]        sh_bytes;
	logic [WORK_W-1:0] targ;
	logic [WORK_W-1:0] den;
	logic              neg;
	logic              ovf;

	logic [WORK_W:0]   rx;
	logic [WORK_W+1:0] diff;
	logic              ge;

	// Decode of the compact word
	always_comb begin
		expo     = cmp_q[31:24];
		mant     = cmp_q[22:0];
		meff     = mant;
		sh_bytes = expo - 8'd3;
		targ     = '0;
		den      = '0;
		if (expo <= 8'd3) begin
			unique case (expo[1:0])
				2'd0:    meff = '0;
				2'd1:    meff = mant >> 16;
				2'd2:    meff = mant >> 8;
				default: meff = mant;
			endcase
			targ = WORK_W'(meff);
			den  = WORK_W'({1'b0, meff} + 24'd1);
		end else begin
			// byte shift of at least one, so bit 0 is clear and +1 is an OR
			if (sh_bytes < 8'd32) begin
				targ = WORK_W'(mant) << {sh_bytes[4:0], 3'b000};
			end
			den = targ | WORK_W'(1);
		end
		neg = (meff != '0) && cmp_q[23];
		ovf = (meff != '0) && ((expo > 8'd34) ||
			((meff > 23'h0000ff) && (expo > 8'd33)) ||
			((meff > 23'h00ffff) && (expo > 8'd32)));
	end

	// Restoring division step: shift in next numerator bit, trial subtract
	always_comb begin
		rx   = {rem_q, quo_q[WORK_W-1]};
		diff = {1'b0, rx} - {2'b00, den_q};
		ge   = ~diff[WORK_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmp_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= '0;
			neg_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				cmp_q <= compact_bits;
			end
			if (cmd.load) begin
				rem_q <= '0;
				quo_q <= ~targ;
				den_q <= den;
				neg_q <= neg;
				ovf_q <= ovf;
			end else if (cmd.step) begin
				rem_q <= ge ? diff[WORK_W-1:0] : rx[WORK_W-1:0];
				quo_q <= {quo_q[WORK_W-2:0], ge};
			end else if (cmd.inc) begin
				quo_q <= quo_q + WORK_W'(1);
			end else if (cmd.shift) begin
				quo_q <= quo_q >> WORD_W;
			end
		end
	end

	assign work_word       = quo_q[WORD_W-1:0];
	assign target_negative = neg_q;
	assign target_overflow = ovf_q;

endmodule

// File: hdl/bwct_ctrl.sv
module bwct_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bwct_pkg::IDX_W-1:0]  word_index,
	output logic                        last_word,
	output bwct_pkg::ctrl_cmd_t         cmd
);
	import bwct_pkg::*;
	`include "block_work_from_compact_target_unit_defines.svh"

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(WORK_W - 1);
	localparam logic [IDX_W-1:0]  WORD_LAST = IDX_W'(NUM_WORDS - 1);

	state_t            state_q;
	state_t            state_d;
	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0]  word_q;
	logic              out_xfer;

	assign out_xfer = out_valid && out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_LOAD;
			ST_LOAD: state_d = ST_DIV;
			ST_DIV:  if (step_q == STEP_LAST) state_d = ST_INC;
			ST_INC:  state_d = ST_OUT;
			ST_OUT:  if (out_xfer && (word_q == WORD_LAST)) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		out_valid   = (state_q == ST_OUT);
		cmd.capture = in_ready && in_valid;
		cmd.load    = (state_q == ST_LOAD);
		cmd.step    = (state_q == ST_DIV);
		cmd.inc     = (state_q == ST_INC);
		cmd.shift   = out_xfer;
	end

	assign word_index = word_q;
	assign last_word  = (word_q == WORD_LAST);

	// State, division step count, output word count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			word_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				step_q <= '0;
				word_q <= '0;
			end else begin
				if (cmd.step) step_q <= step_q + STEP_W'(1);
				if (out_xfer) word_q <= word_q + IDX_W'(1);
			end
		end
	end

	`BWCT_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)
	`BWCT_ASSERT_NEXT(a_accept_loads, in_valid && in_ready, state_q == ST_LOAD)
	`BWCT_ASSERT_NEXT(a_div_ends, (state_q == ST_DIV) && (step_q == STEP_LAST),
		state_q == ST_INC)
	`BWCT_ASSERT_NEXT(a_last_frees, out_xfer && last_word, in_ready)

endmodule

// File: hdl/block_work_from_compact_target_unit.sv
// Expected work from a compact target word.
// Input channel: in_valid / in_ready carry one 32-bit compact_bits per transfer
// (byte exponent, sign bit, 23-bit mantissa).
// Output channel: out_valid / out_ready carry four transfers per input, the
// 256-bit work value in 64-bit work_word slices, word_index 0 first, last_word
// set on slice 3. target_negative and target_overflow repeat the decode flags
// on every slice.
// Sequence: after the input transfer the controller decodes the target in ST_LOAD,
// runs the bit-serial restoring division in ST_DIV (one 257-bit trial subtract per
// cycle), applies the final increment in ST_INC, then sends the four output words.
// The serial divider handles one item at a time; in_ready is high only while
// the block is empty.
// Reset (arst_n low) returns the controller to idle and discards any item in
// flight. When the receiver stalls, the current slice is held unchanged on
// the output ports until it is taken.
module block_work_from_compact_target_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [bwct_pkg::CMP_W-1:0]  compact_bits,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bwct_pkg::IDX_W-1:0]  word_index,
	output logic [bwct_pkg::WORD_W-1:0] work_word,
	output logic                        last_word,
	output logic                        target_negative,
	output logic                        target_overflow
);
	import bwct_pkg::*;

	ctrl_cmd_t cmd;

	bwct_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word_index (word_index),
		.last_word  (last_word),
		.cmd        (cmd)
	);

	bwct_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.compact_bits    (compact_bits),
		.work_word       (work_word),
		.target_negative (target_negative),
		.target_overflow (target_overflow)
	);

endmodule

// File: verif/block_work_from_compact_target_unit_tb.sv
`timescale 1ns / 1ps

module block_work_from_compact_target_unit_tb;

	import bwct_pkg::*;

	localparam int ITEM_TOTAL    = 430;
	localparam int TAIL_ITEMS    = 40;
	localparam int HOLD_CYCLES   = 700;
	localparam int DRAIN_CYCLES  = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int REPORT_LIMIT  = 10;

	// One 64-bit slice of the predicted work value
	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [WORD_W-1:0] word;
		logic              last;
		logic              neg;
		logic              ovf;
	} work_slice_t;

	// Scoreboard: predicts the work slices of each accepted compact word
	class work_scoreboard;
		work_slice_t slices_due[$];
		int          failures;
		int          slices_checked;

		function void note_compact(logic [CMP_W-1:0] c);
			logic [7:0]         ex;
			logic [22:0]        mant;
			logic [WORK_W-1:0]  tgt;
			logic [WORK_W-1:0]  work;
			logic               neg;
			logic               ovf;
			int                 sh;
			work_slice_t        s;
			ex   = c[31:24];
			mant = c[22:0];
			// expand the compact form; bits pushed past the top are lost
			if (ex <= 8'd3) begin
				mant = mant >> (8 * (3 - int'(ex)));
				tgt  = WORK_W'(mant);
			end else begin
				sh  = 8 * (int'(ex) - 3);
				tgt = (sh >= WORK_W) ? '0 : (WORK_W'(mant) << sh);
			end
			neg = (mant != 0) && c[23];
			ovf = (mant != 0) && (ex > 8'd34 || (mant > 23'hff && ex > 8'd33) ||
				(mant > 23'hffff && ex > 8'd32));
			// T has at most 23 set bits, so T + 1 never wraps; sum wraps mod 2^256
			work = (~tgt) / (tgt + 1'b1) + 1'b1;
			for (int k = 0; k < NUM_WORDS; k++) begin
				s.idx  = IDX_W'(k);
				s.word = work[k*WORD_W +: WORD_W];
				s.last = (k == NUM_WORDS - 1);
				s.neg  = neg;
				s.ovf  = ovf;
				slices_due.push_back(s);
			end
		endfunction

		function void flag(string msg);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("[%0t] mismatch: %s", $time, msg);
		endfunction

		function void check_word(logic [IDX_W-1:0] idx, logic [WORD_W-1:0] word,
				logic last, logic neg, logic ovf);
			work_slice_t s;
			slices_checked++;
			if (slices_due.size() == 0) begin
				flag($sformatf("unexpected slice idx=%0d word=%h", idx, word));
				return;
			end
			s = slices_due.pop_front();
			if (idx !== s.idx || word !== s.word || last !== s.last ||
					neg !== s.neg || ovf !== s.ovf)
				flag($sformatf("exp idx=%0d word=%h last=%b neg=%b ovf=%b, got idx=%0d word=%h last=%b neg=%b ovf=%b",
					s.idx, s.word, s.last, s.neg, s.ovf, idx, word, last, neg, ovf));
		endfunction

		function int pending();
			return slices_due.size();
		endfunction
	endclass

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [CMP_W-1:0]  compact_bits = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [IDX_W-1:0]  word_index;
	logic [WORD_W-1:0] work_word;
	logic              last_word;
	logic              target_negative;
	logic              target_overflow;

	bit                quiet_tail = 1'b0;
	work_scoreboard    sb = new();

	block_work_from_compact_target_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.compact_bits    (compact_bits),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.word_index      (word_index),
		.work_word       (work_word),
		.last_word       (last_word),
		.target_negative (target_negative),
		.target_overflow (target_overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one compact word after an optional idle gap; return on transfer
	task automatic send_compact(input logic [CMP_W-1:0] c, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		compact_bits <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_compact(c);
	endtask

	function automatic int pick_gap();
		if (quiet_tail || $urandom_range(0, 2) != 0)
			return 0;
		return $urandom_range(1, 13);
	endfunction

	// Random compact word, mostly with exponents around the interesting range
	function automatic logic [CMP_W-1:0] pick_compact();
		logic [7:0]  ex;
		logic [22:0] mant;
		if ($urandom_range(0, 9) == 0)
			return $urandom;
		ex = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 36));
		case ($urandom_range(0, 5))
			0: mant = 23'($urandom_range(0, 255));
			1: mant = 23'($urandom_range(0, 65535));
			2: begin
				case ($urandom_range(0, 5))
					0: mant = 23'hff;
					1: mant = 23'h100;
					2: mant = 23'hffff;
					3: mant = 23'h10000;
					4: mant = 23'h7fffff;
					default: mant = '0;
				endcase
			end
			default: mant = 23'($urandom);
		endcase
		return {ex, 1'($urandom), mant};
	endfunction

	// Stimulus
	initial begin : stimulus
		logic [CMP_W-1:0] directed [$];
		directed = '{
			32'h0000_0000,  // zero target, work wraps to zero
			32'hffff_ffff,  // huge exponent, sign set, target shifted out
			32'h1d00_ffff,
			32'h0300_0001,  // target of one
			32'h0012_3456,  // exponent zero drops the whole mantissa
			32'h01ff_ffff,
			32'h0200_8000,
			32'h0380_0001,  // sign bit with nonzero mantissa
			32'h0480_0000,  // sign bit with zero mantissa
			32'h2000_ffff,
			32'h2001_0000,  // overflow boundary at exponent 32
			32'h2100_00ff,
			32'h2100_0100,  // overflow boundary at exponent 33
			32'h2200_0001,
			32'h2200_0100,  // overflow boundary at exponent 34
			32'h2300_0001,  // shift of 256 bits, target zero
			32'h227f_ffff,
			32'h2000_0001,
			32'h0400_0000,
			32'h037f_ffff,
			32'h5a7f_ffff,
			32'hff00_0001
		};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			send_compact(directed[i], pick_gap());
		for (int n = directed.size(); n < ITEM_TOTAL; n++) begin
			if (n >= ITEM_TOTAL - TAIL_ITEMS)
				quiet_tail = 1'b1;
			send_compact(pick_compact(), pick_gap());
		end
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Receiver: check each transfer, then pick ready for the next cycle
	initial begin : receiver
		int stall_left;
		int cyc;
		bit calm;
		bit hold_done;
		stall_left = 0;
		cyc        = 0;
		calm       = 1'b0;
		hold_done  = 1'b0;
		forever begin
			@(posedge clk);
			cyc++;
			if (arst_n && out_valid && out_ready)
				sb.check_word(word_index, work_word, last_word, target_negative,
					target_overflow);
			if (cyc % 500 == 0)
				calm = ($urandom_range(0, 3) == 0);
			// one long hold-off so the block backs up into the input side
			if (!hold_done && sb.slices_checked >= 200) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && !quiet_tail &&
					$urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 13);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: too many cycles without any transfer ends the run
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

endmodule
